// ===== src/fvcw_pkg.sv =====
// Shared types, constants and helper functions of the flow colour wheel.
// Used by every module of the block; depends on nothing else.
package fvcw_pkg;

  localparam int FLOW_WIDTH     = 16;
  localparam int FLOW_FRAC_BITS = 8;
  localparam int WHEEL_SIZE     = 55;

  localparam int RY = 15;
  localparam int YG = 6;
  localparam int GC = 4;
  localparam int CB = 11;
  localparam int BM = 13;
  localparam int MR = 6;

  localparam int PHASE_BITS   = 17;
  localparam int HALF_TURN    = 65536;
  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_WIDTH = FLOW_WIDTH + 18;
  localparam int ANGLE_WIDTH  = 20;
  localparam int MIX_WIDTH    = 26;
  localparam int POS_WIDTH    = PHASE_BITS + 6;
  localparam int MAXR_WIDTH   = 16;
  localparam int ITER_CYCLES  = (FLOW_WIDTH > CORDIC_ITERS) ? FLOW_WIDTH : CORDIC_ITERS;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [MAXR_WIDTH-1:0] MAXR_RESET = MAXR_WIDTH'(1 << FLOW_FRAC_BITS);

  typedef struct packed {
    logic                         mode;
    logic                         frame_start;
    logic signed [FLOW_WIDTH-1:0] flow_x;
    logic signed [FLOW_WIDTH-1:0] flow_y;
    logic                         flow_valid;
  } flow_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } flow_out_t;

  typedef enum logic [1:0] {
    KIND_MEASURE,
    KIND_MARK,
    KIND_COLOR,
    KIND_BLACK
  } job_kind_e;

  typedef struct packed {
    job_kind_e                    kind;
    logic                         frame_start;
    logic signed [FLOW_WIDTH-1:0] flow_x;
    logic signed [FLOW_WIDTH-1:0] flow_y;
  } job_t;

  // arctan(2^-i) in units of pi/65536
  function automatic logic [14:0] atan_step(logic [3:0] idx);
    logic [14:0] a;
    unique case (idx)
      4'd0:  a = 15'd16384;
      4'd1:  a = 15'd9672;
      4'd2:  a = 15'd5110;
      4'd3:  a = 15'd2594;
      4'd4:  a = 15'd1302;
      4'd5:  a = 15'd652;
      4'd6:  a = 15'd326;
      4'd7:  a = 15'd163;
      4'd8:  a = 15'd81;
      4'd9:  a = 15'd41;
      4'd10: a = 15'd20;
      4'd11: a = 15'd10;
      4'd12: a = 15'd5;
      4'd13: a = 15'd3;
      4'd14: a = 15'd1;
      4'd15: a = 15'd1;
      default: a = 15'd0;
    endcase
    return a;
  endfunction

  // arithmetic shift that rounds toward zero
  function automatic logic [CORDIC_WIDTH-1:0] shr_tz(logic [CORDIC_WIDTH-1:0] v,
                                                     logic [3:0] s);
    logic [CORDIC_WIDTH-1:0] mag;
    mag = v[CORDIC_WIDTH-1] ? -v : v;
    mag = mag >> s;
    return v[CORDIC_WIDTH-1] ? -mag : mag;
  endfunction

  function automatic flow_out_t wheel_rgb(logic [5:0] k_in);
    int        k;
    int        i;
    int        r;
    int        g;
    int        b;
    flow_out_t c;
    k = int'(k_in);
    if (k > WHEEL_SIZE - 1) k = WHEEL_SIZE - 1;
    if (k < RY) begin
      i = k; r = 255; g = 255 * i / RY; b = 0;
    end else if (k < RY + YG) begin
      i = k - RY; r = 255 - 255 * i / YG; g = 255; b = 0;
    end else if (k < RY + YG + GC) begin
      i = k - RY - YG; r = 0; g = 255; b = 255 * i / GC;
    end else if (k < RY + YG + GC + CB) begin
      i = k - RY - YG - GC; r = 0; g = 255 - 255 * i / CB; b = 255;
    end else if (k < RY + YG + GC + CB + BM) begin
      i = k - RY - YG - GC - CB; r = 255 * i / BM; g = 0; b = 255;
    end else begin
      i = k - RY - YG - GC - CB - BM; r = 255; g = 0; b = 255 - 255 * i / MR;
    end
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    return c;
  endfunction

endpackage

// ===== src/fvcw_front.sv =====
// Front end: takes input beats and classifies them into jobs for the back end.
// Depends on fvcw_pkg.
module fvcw_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fvcw_pkg::flow_in_t in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output fvcw_pkg::job_t     job_o
);

  always_comb begin
    job_o.frame_start = in_data_i.frame_start;
    job_o.flow_x      = in_data_i.flow_x;
    job_o.flow_y      = in_data_i.flow_y;
    priority if (!in_data_i.mode && in_data_i.flow_valid) begin
      job_o.kind = fvcw_pkg::KIND_MEASURE;
    end else if (!in_data_i.mode) begin
      job_o.kind = fvcw_pkg::KIND_MARK;
    end else if (in_data_i.flow_valid) begin
      job_o.kind = fvcw_pkg::KIND_COLOR;
    end else begin
      job_o.kind = fvcw_pkg::KIND_BLACK;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// ===== src/fvcw_queue.sv =====
// Short job queue between the front and back ends.
// Depends on fvcw_pkg.
module fvcw_queue #(
  parameter int DEPTH = fvcw_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fvcw_pkg::job_t job_i,
  input  logic           pop_i,
  output fvcw_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  fvcw_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/fvcw_back.sv =====
// Back end: radius by bit-serial square root, phase by iterative CORDIC, wheel
// mix and normalising divide; holds max radius and the output register. Uses fvcw_pkg.
module fvcw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fvcw_pkg::job_t        job_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  logic [15:0]           fixed_max_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output fvcw_pkg::flow_out_t   out_data_o
);

  localparam int W    = fvcw_pkg::FLOW_WIDTH;
  localparam int SW   = 2 * W;
  localparam int CW   = fvcw_pkg::CORDIC_WIDTH;
  localparam int ZW   = fvcw_pkg::ANGLE_WIDTH;
  localparam int MW   = fvcw_pkg::MIX_WIDTH;
  localparam int PW   = W + MW;
  localparam int NW   = fvcw_pkg::POS_WIDTH;
  localparam int RW   = fvcw_pkg::MAXR_WIDTH;
  localparam int PB   = fvcw_pkg::PHASE_BITS;
  localparam int CntW = $clog2(fvcw_pkg::ITER_CYCLES + 1);
  localparam int EW   = W + RW;

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_SUM, S_ITER, S_PHASE, S_MIX, S_PROD, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e                   state_q;
  fvcw_pkg::job_t           job_q;
  logic [RW-1:0]            maxr_q;
  logic [SW-1:0]            sq_x_q, sq_y_q;
  logic [SW-1:0]            rem_q, root_q, bit_q;
  logic [CW-1:0]            cx_q, cy_q;
  logic signed [ZW-1:0]     cz_q;
  logic                     special_q;
  logic [CntW-1:0]          cnt_q;
  logic [NW-1:0]            pos_q;
  logic [MW-1:0]            mix_q [3];
  logic [RW-1:0]            m_q;
  logic                     le_q;
  logic [PW-1:0]            drem_q [3];
  logic [7:0]               quot_q [3];
  logic [7:0]               dim_q [3];
  logic [2:0]               dstep_q;
  fvcw_pkg::flow_out_t      res_q;
  logic                     out_valid_q;
  fvcw_pkg::flow_out_t      out_data_q;

  logic [W-1:0]             ax, ay;
  logic [CW-1:0]            x0, y0;
  logic signed [ZW-1:0]     z0;
  logic                     special0;
  logic [SW-1:0]            trial;
  logic [CW-1:0]            xs, ys, cx_n, cy_n;
  logic signed [ZW-1:0]     cz_n;
  logic [3:0]               cidx;
  logic signed [ZW-1:0]     pz;
  logic [PB-1:0]            phase;
  logic [5:0]               k0, k1;
  logic [PB-1:0]            frac;
  fvcw_pkg::flow_out_t      w0, w1;
  logic [7:0]               w0c [3], w1c [3];
  logic [MW-1:0]            mix_n [3];
  logic [RW-1:0]            m_n;
  logic [W-1:0]             r_w;
  logic [RW-1:0]            r_sat;
  logic [PW-1:0]            dden;
  logic                     out_load;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign r_w         = root_q[W-1:0];
  assign r_sat       = (EW'(r_w) > EW'({RW{1'b1}})) ? {RW{1'b1}} : RW'(r_w);

  // magnitudes and CORDIC start point, with the axis cases resolved up front
  always_comb begin
    ax = job_q.flow_x[W-1] ? W'(-job_q.flow_x) : W'(job_q.flow_x);
    ay = job_q.flow_y[W-1] ? W'(-job_q.flow_y) : W'(job_q.flow_y);
    x0 = -CW'(job_q.flow_x);
    y0 = -CW'(job_q.flow_y);
    z0 = '0;
    special0 = 1'b0;
    priority if (job_q.flow_y == '0) begin
      special0 = 1'b1;
      z0 = job_q.flow_x[W-1] ? ZW'(0) : -ZW'(fvcw_pkg::HALF_TURN);
    end else if (job_q.flow_x == '0) begin
      special0 = 1'b1;
      z0 = job_q.flow_y[W-1] ? ZW'(fvcw_pkg::HALF_TURN / 2) : -ZW'(fvcw_pkg::HALF_TURN / 2);
    end else if (x0[CW-1]) begin
      z0 = (!y0[CW-1] && y0 != '0) ? ZW'(fvcw_pkg::HALF_TURN) : -ZW'(fvcw_pkg::HALF_TURN);
      x0 = -x0;
      y0 = -y0;
    end else begin
      z0 = '0;
    end
    x0 = x0 << 16;
    y0 = y0 << 16;
  end

  always_comb begin
    trial = root_q + bit_q;
    cidx  = cnt_q[3:0];
    xs    = fvcw_pkg::shr_tz(cx_q, cidx);
    ys    = fvcw_pkg::shr_tz(cy_q, cidx);
    if (!cy_q[CW-1] && cy_q != '0) begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + signed'(ZW'(fvcw_pkg::atan_step(cidx)));
    end else begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - signed'(ZW'(fvcw_pkg::atan_step(cidx)));
    end
  end

  always_comb begin
    pz = cz_q + ZW'(fvcw_pkg::HALF_TURN);
    priority if (pz < 0) begin
      phase = '0;
    end else if (pz > signed'(ZW'((1 << PB) - 1))) begin
      phase = {PB{1'b1}};
    end else begin
      phase = pz[PB-1:0];
    end
  end

  always_comb begin
    k0   = pos_q[NW-1:PB];
    frac = pos_q[PB-1:0];
    k1   = (k0 == 6'(fvcw_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;
    w0   = fvcw_pkg::wheel_rgb(k0);
    w1   = fvcw_pkg::wheel_rgb(k1);
    w0c[0] = w0.red;  w0c[1] = w0.green;  w0c[2] = w0.blue;
    w1c[0] = w1.red;  w1c[1] = w1.green;  w1c[2] = w1.blue;
    for (int c = 0; c < 3; c++) begin
      mix_n[c] = MW'((PB + 1)'(1 << PB) - (PB + 1)'(frac)) * MW'(w0c[c])
               + MW'(frac) * MW'(w1c[c]);
    end
    m_n = (fixed_max_i != '0) ? fixed_max_i : maxr_q;
    if (m_n == '0) m_n = RW'(1);
    dden = PW'(m_q) << (PB + int'(dstep_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      maxr_q      <= fvcw_pkg::MAXR_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dstep_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            job_q <= job_i;
            if ((job_i.kind == fvcw_pkg::KIND_MEASURE || job_i.kind == fvcw_pkg::KIND_MARK)
                && job_i.frame_start) begin
              maxr_q <= fvcw_pkg::MAXR_RESET;
            end
            unique case (job_i.kind)
              fvcw_pkg::KIND_MEASURE, fvcw_pkg::KIND_COLOR: state_q <= S_SQUARE;
              fvcw_pkg::KIND_BLACK: begin
                res_q   <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SQUARE: begin
          sq_x_q    <= SW'(ax) * SW'(ax);
          sq_y_q    <= SW'(ay) * SW'(ay);
          cx_q      <= x0;
          cy_q      <= y0;
          cz_q      <= z0;
          special_q <= special0;
          state_q   <= S_SUM;
        end
        S_SUM: begin
          rem_q   <= sq_x_q + sq_y_q;
          root_q  <= '0;
          bit_q   <= SW'(1) << (SW - 2);
          cnt_q   <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          // one root bit and one rotation per cycle; the rotation is skipped for an axis case
          if (cnt_q < CntW'(W)) begin
            if (rem_q >= trial) begin
              rem_q  <= rem_q - trial;
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
          if (cnt_q < CntW'(fvcw_pkg::CORDIC_ITERS) && !special_q) begin
            cx_q <= cx_n;
            cy_q <= cy_n;
            cz_q <= cz_n;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(fvcw_pkg::ITER_CYCLES - 1)) begin
            state_q <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (job_q.kind == fvcw_pkg::KIND_MEASURE) begin
            state_q <= S_IDLE;
          end else begin
            pos_q   <= NW'(phase) * NW'(fvcw_pkg::WHEEL_SIZE - 1);
            state_q <= S_MIX;
          end
        end
        S_MIX: begin
          for (int c = 0; c < 3; c++) mix_q[c] <= mix_n[c];
          m_q     <= m_n;
          le_q    <= EW'(r_w) <= EW'(m_n);
          state_q <= S_PROD;
        end
        S_PROD: begin
          for (int c = 0; c < 3; c++) begin
            drem_q[c] <= PW'(r_w) * PW'(MW'(255 << PB) - mix_q[c]);
            dim_q[c]  <= 8'((28'(mix_q[c]) * 28'd3) >> (PB + 2));
            quot_q[c] <= '0;
          end
          dstep_q <= 3'd7;
          state_q <= S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (drem_q[c] >= dden) begin
              drem_q[c]          <= drem_q[c] - dden;
              quot_q[c][dstep_q] <= 1'b1;
            end
          end
          dstep_q <= dstep_q - 1'b1;
          if (dstep_q == 3'd0) state_q <= S_FIN;
        end
        S_FIN: begin
          // within the maximum radius, round the quotient up where a remainder is left; else dim the mix
          if (le_q) begin
            res_q.red   <= 8'(9'd255 - 9'(quot_q[0]) - 9'(drem_q[0] != '0));
            res_q.green <= 8'(9'd255 - 9'(quot_q[1]) - 9'(drem_q[1] != '0));
            res_q.blue  <= 8'(9'd255 - 9'(quot_q[2]) - 9'(drem_q[2] != '0));
          end else begin
            res_q.red   <= dim_q[0];
            res_q.green <= dim_q[1];
            res_q.blue  <= dim_q[2];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_PHASE && job_q.kind == fvcw_pkg::KIND_MEASURE && r_sat > maxr_q) begin
        maxr_q <= r_sat;
      end
    end
  end

endmodule

// ===== src/flow_vector_color_wheel.sv =====
// Optical-flow colour wheel: flow vectors in, RGB pixels out.
// Top level; instantiates fvcw_front, fvcw_queue and fvcw_back, uses fvcw_pkg.
//
// Usage: stream each frame twice over the input channel (valid/stall). Beats
// with mode 0 form the measure pass and raise the running maximum radius
// (frame_start first returns it to 1.0); they give no output beat. Beats with
// mode 1 form the colourise pass and give one RGB beat each, in order, on the
// output channel (valid/stall). Invalid vectors give black.
// The config channel (valid/ready, always ready) loads fixed_max_motion;
// zero selects the measured maximum. Write it only while the block is idle.
// Back end: takes one item at a time. Root and CORDIC share a 16-step iteration
// phase; a measure beat ends there, while a colourise beat goes on to the wheel
// mix and an 8-step restoring divide, one per channel in lockstep, then the
// output register. A black pixel goes straight to the output register, and an
// invalid measure beat ends as its job leaves the queue.
// A two-entry job queue lets input be taken while the back end is busy.
// Reset empties the queue, drops any output beat and sets the maximum to 1.0.
// When the receiver stalls, the output beat holds and the back end waits,
// so the queue fills and the input stalls in turn.
module flow_vector_color_wheel #(
  parameter int QUEUE_DEPTH = fvcw_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fvcw_pkg::flow_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fvcw_pkg::flow_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_fixed_max_motion_i
);

  logic           push, pop, q_full, q_empty;
  fvcw_pkg::job_t push_job, pop_job;
  logic [15:0]    fixed_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_max_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fixed_max_q <= cfg_fixed_max_motion_i;
    end
  end

  fvcw_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  fvcw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fvcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .fixed_max_i (fixed_max_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/fvcw_checker.sv =====
// Port-level checks on the flow colour wheel, bound to the top level.
// Depends on fvcw_pkg and flow_vector_color_wheel.
module fvcw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fvcw_pkg::flow_out_t out_data_o
);

  a_reset_no_out: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output beat shown during reset");

  a_reset_no_stall: assert property (@(posedge clk_i) !rst_ni |-> !in_stall_o)
    else $error("input stalled during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled output beat changed");

endmodule

bind flow_vector_color_wheel fvcw_checker u_checker (.*);

// ===== bench/tb_flow_vector_color_wheel.sv =====
// Testbench of flow_vector_color_wheel: random and directed flow vectors with a
// scoreboard that predicts each pixel in fixed point. Depends on fvcw_pkg and the block.
`timescale 1ns / 1ps

module tb_flow_vector_color_wheel;

  class pixel_board;
    logic [15:0]           fixed_norm;
    logic [15:0]           peak_radius;
    fvcw_pkg::flow_out_t   pending[$];
    int                    mismatches;
    int                    checked;

    function new();
      fixed_norm  = 16'd0;
      peak_radius = 16'd256;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint unsigned radius(longint fx, longint fy);
      longint unsigned ax;
      longint unsigned ay;
      ax = fx < 0 ? -fx : fx;
      ay = fy < 0 ? -fy : fy;
      return root_of(ax * ax + ay * ay);
    endfunction

    function automatic longint tz(longint v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
    endfunction

    function automatic longint unsigned angle_of(longint fx, longint fy);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint p;
      longint steps[16];
      steps = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      if (fy == 0) return fx >= 0 ? 0 : fvcw_pkg::HALF_TURN;
      if (fx == 0) begin
        return fy < 0 ? fvcw_pkg::HALF_TURN + fvcw_pkg::HALF_TURN / 2
                      : fvcw_pkg::HALF_TURN / 2;
      end
      x = -fx;
      y = -fy;
      z = 0;
      if (x < 0) begin
        z = y > 0 ? fvcw_pkg::HALF_TURN : -fvcw_pkg::HALF_TURN;
        x = -x;
        y = -y;
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < 16; i++) begin
        xs = tz(x, i);
        ys = tz(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += steps[i];
        end else begin
          x -= ys; y += xs; z -= steps[i];
        end
      end
      p = z + fvcw_pkg::HALF_TURN;
      if (p < 0) p = 0;
      if (p > 131071) p = 131071;
      return p;
    endfunction

    function automatic int hue(int k, int ch);
      int i;
      int r;
      int g;
      int b;
      if (k > 54) k = 54;
      if (k < 15) begin
        i = k; r = 255; g = 255 * i / 15; b = 0;
      end else if (k < 21) begin
        i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
      end else if (k < 25) begin
        i = k - 21; r = 0; g = 255; b = 255 * i / 4;
      end else if (k < 36) begin
        i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
      end else if (k < 49) begin
        i = k - 36; r = 255 * i / 13; g = 0; b = 255;
      end else begin
        i = k - 49; r = 255; g = 0; b = 255 - 255 * i / 6;
      end
      return ch == 0 ? r : (ch == 1 ? g : b);
    endfunction

    function void note_input(fvcw_pkg::flow_in_t it);
      longint fx;
      longint fy;
      longint unsigned r;
      longint unsigned m;
      longint unsigned n;
      longint unsigned fr;
      longint unsigned c;
      longint unsigned d;
      longint unsigned den;
      longint unsigned o[3];
      int k0;
      int k1;
      fvcw_pkg::flow_out_t px;
      fx = longint'(it.flow_x);
      fy = longint'(it.flow_y);
      if (!it.mode) begin
        if (it.frame_start) peak_radius = 16'd256;
        if (it.flow_valid) begin
          r = radius(fx, fy);
          if (r > 65535) r = 65535;
          if (r > peak_radius) peak_radius = r[15:0];
        end
        return;
      end
      if (!it.flow_valid) begin
        pending.push_back('0);
        return;
      end
      m = fixed_norm != 0 ? fixed_norm : peak_radius;
      if (m == 0) m = 1;
      r = radius(fx, fy);
      n = angle_of(fx, fy) * 54;
      k0 = int'(n >> 17);
      fr = n & 64'h1FFFF;
      k1 = (k0 + 1) % 55;
      for (int ch = 0; ch < 3; ch++) begin
        c = (131072 - fr) * hue(k0, ch) + fr * hue(k1, ch);
        if (r <= m) begin
          d = 255 * 131072 - c;
          den = m << 17;
          o[ch] = 255 - (r * d + den - 1) / den;
        end else begin
          o[ch] = (3 * c) >> 19;
        end
      end
      px.red   = o[0][7:0];
      px.green = o[1][7:0];
      px.blue  = o[2][7:0];
      pending.push_back(px);
    endfunction

    function void check_pixel(fvcw_pkg::flow_out_t got);
      fvcw_pkg::flow_out_t exp_px;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", got);
        return;
      end
      exp_px = pending.pop_front();
      if (got.red !== exp_px.red || got.green !== exp_px.green ||
          got.blue !== exp_px.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                   exp_px.red, exp_px.green, exp_px.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  fvcw_pkg::flow_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  fvcw_pkg::flow_out_t out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [15:0]         cfg_fixed_max_motion_i;

  pixel_board board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int quiet_cycles;
  int accepted;

  flow_vector_color_wheel DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_fixed_max_motion_i(cfg_fixed_max_motion_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && rst_ni) board.check_pixel(out_data_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays high after the beat; callers that wait drop it first
  task automatic send_item(fvcw_pkg::flow_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(it);
    accepted++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    // a measure beat may still be in flight
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_norm(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_fixed_max_motion_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.fixed_norm = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic fvcw_pkg::flow_in_t mk(bit md, bit st, int fx, int fy, bit vl);
    fvcw_pkg::flow_in_t it;
    it.mode = md; it.frame_start = st; it.flow_x = fx[15:0];
    it.flow_y = fy[15:0]; it.flow_valid = vl;
    return it;
  endfunction

  function automatic int rnd_flow();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return int'($urandom_range(2048)) - 1024;
      2: return int'($urandom_range(20)) - 10;
      default: return $urandom_range(1) ? 32767 : -32768;
    endcase
  endfunction

  // one frame: measure pass then colourise pass over the same vectors
  task automatic run_frame(int len);
    fvcw_pkg::flow_in_t vecs[$];
    fvcw_pkg::flow_in_t it;
    for (int i = 0; i < len; i++)
      vecs.push_back(mk(0, 0, rnd_flow(), rnd_flow(), $urandom_range(9) != 0));
    foreach (vecs[i]) begin
      it = vecs[i];
      it.frame_start = (i == 0) || ($urandom_range(49) == 0);
      send_item(it);
    end
    foreach (vecs[i]) begin
      it = vecs[i];
      it.mode = 1'b1;
      it.frame_start = $urandom_range(1);
      send_item(it);
    end
  endtask

  initial begin
    logic [15:0] norms[6];
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_fixed_max_motion_i = '0;
    hold_off = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 73;
    accepted = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, axis cases, invalid vectors, stray frame_start
    send_item(mk(0, 1, 32767, -32768, 1));
    send_item(mk(0, 0, 5000, 5000, 0));
    send_item(mk(1, 1, 32767, -32768, 1));
    send_item(mk(1, 0, 100, 0, 1));
    send_item(mk(1, 0, -100, 0, 1));
    send_item(mk(1, 0, 0, -100, 1));
    send_item(mk(1, 0, 0, 100, 1));
    send_item(mk(1, 0, 0, 0, 1));
    send_item(mk(1, 0, -32768, -32768, 1));
    send_item(mk(1, 0, 1234, -999, 0));
    send_item(mk(0, 1, 10, 10, 1));
    send_item(mk(1, 0, 10, 10, 1));
    send_item(mk(1, 0, 300, -300, 1));
    send_item(mk(1, 0, -1, 1, 1));
    drain();

    norms = '{16'hFFFF, 16'd1, 16'd256, 16'd0, 16'd4000, 16'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_norm(norms[ph]);
      if (ph == 2) begin send_idle_pct = 73; recv_idle_pct = 27; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int f = 0; f < 9; f++) begin
        if (ph == 1 && f == 3) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (600) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        run_frame($urandom_range(1) ? $urandom_range(3, 8) : $urandom_range(15, 30));
        if (f == 5) begin
          in_valid_i <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("covered %0d input beats and %0d pixels over six normaliser settings",
             accepted, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/fvcw_pkg.sv
src/fvcw_front.sv
src/fvcw_queue.sv
src/fvcw_back.sv
src/flow_vector_color_wheel.sv
src/fvcw_checker.sv
bench/tb_flow_vector_color_wheel.sv
